// File: src/fdm_pkg.sv
// ----------------------------------------------------------------------------
// fdm_pkg
// shared constants and types of the frequency and duty-cycle meter
// ----------------------------------------------------------------------------
package fdm_pkg;

  localparam int unsigned CountWidth = 32;
  localparam int unsigned GateWidth  = 32;
  localparam int unsigned DutyWidth  = 7;
  localparam int unsigned NumWidth   = CountWidth + 7;
  localparam int unsigned QuoWidth   = 8;
  localparam int unsigned QueueDepth = 2;

  localparam logic [GateWidth-1:0]  GateReset   = GateWidth'(1000000);
  localparam logic [CountWidth-1:0] CountMax    = {CountWidth{1'b1}};
  localparam logic [DutyWidth-1:0]  DutyPercent = DutyWidth'(100);

  localparam logic KindDuty = 1'b0;
  localparam logic KindGate = 1'b1;

  typedef struct packed {
    logic                  has_duty;
    logic                  has_gate;
    logic [CountWidth-1:0] period;
    logic [CountWidth-1:0] high;
    logic [CountWidth-1:0] edges;
  } job_t;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    sat_inc = (v == CountMax) ? CountMax : v + CountWidth'(1);
  endfunction

endpackage

// File: src/frequency_duty_cycle_meter_core.sv
// ----------------------------------------------------------------------------
// frequency_duty_cycle_meter_core
// one sample per request; reports period, high time and duty on rising
// edges, and the rising edge count at the close of each gate window
// ----------------------------------------------------------------------------
// throughput: one sample per cycle while the two-entry job queue has room
// a gate-only job goes from the queue straight to the output register; a duty
// job first passes one multiply step and eight division steps in the back end.
// The back end takes no new job until its last result is taken, so very short
// periods stall sampling once the queue fills
// reset: asynchronous active low, counters cleared, gate_ticks to 1000000
module frequency_duty_cycle_meter_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fdm_pkg::GateWidth-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           signal_level_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           kind_o,
  output logic [fdm_pkg::CountWidth-1:0] edge_count_o,
  output logic [fdm_pkg::CountWidth-1:0] period_ticks_o,
  output logic [fdm_pkg::CountWidth-1:0] high_ticks_o,
  output logic [fdm_pkg::DutyWidth-1:0]  duty_percent_o,
  output logic                           last_o
);
  import fdm_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_data, pop_data;

  fdm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .signal_level_i (signal_level_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_data_o    (push_data)
  );

  fdm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  fdm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_data_i     (pop_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .edge_count_o   (edge_count_o),
    .period_ticks_o (period_ticks_o),
    .high_ticks_o   (high_ticks_o),
    .duty_percent_o (duty_percent_o),
    .last_o         (last_o)
  );

endmodule

// File: src/fdm_front.sv
// ----------------------------------------------------------------------------
// fdm_front
// edge detection, period / high time / gate window counters, job build
// ----------------------------------------------------------------------------
module fdm_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fdm_pkg::GateWidth-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           signal_level_i,
  output logic                           push_valid_o,
  input  logic                           push_ready_i,
  output fdm_pkg::job_t                  push_data_o
);
  import fdm_pkg::*;

  logic                  prev_q, prev_d;
  logic                  seen_q, seen_d;
  logic [CountWidth-1:0] period_q, period_d;
  logic [CountWidth-1:0] high_q, high_d;
  logic [CountWidth-1:0] gate_q, gate_d;
  logic [CountWidth-1:0] rise_q, rise_d;
  logic [GateWidth-1:0]  gate_ticks_q, gate_ticks_d;

  logic                  accept;
  logic                  rise, fall, gate_hit;
  logic [CountWidth-1:0] elapsed, gate_elapsed, rise_inc;
  job_t                  job;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    rise         = signal_level_i & ~prev_q;
    fall         = ~signal_level_i & prev_q;
    elapsed      = sat_inc(period_q);
    gate_elapsed = sat_inc(gate_q);
    gate_hit     = (gate_elapsed >= gate_ticks_q);
    rise_inc     = rise ? sat_inc(rise_q) : rise_q;

    job.has_duty = rise & seen_q;
    job.has_gate = gate_hit;
    job.period   = elapsed;
    job.high     = high_q;
    job.edges    = rise_inc;

    prev_d       = prev_q;
    seen_d       = seen_q;
    period_d     = period_q;
    high_d       = high_q;
    gate_d       = gate_q;
    rise_d       = rise_q;
    gate_ticks_d = cfg_we_i ? cfg_wdata_i : gate_ticks_q;

    if (accept) begin
      prev_d = signal_level_i;
      if (rise) begin
        seen_d   = 1'b1;
        period_d = '0;
      end else begin
        period_d = elapsed;
        if (fall && seen_q) begin
          high_d = elapsed;
        end
      end
      if (gate_hit) begin
        gate_d = '0;
        rise_d = '0;
      end else begin
        gate_d = gate_elapsed;
        rise_d = rise_inc;
      end
    end
  end

  assign push_valid_o = accept & (job.has_duty | job.has_gate);
  assign push_data_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= 1'b0;
      seen_q       <= 1'b0;
      period_q     <= '0;
      high_q       <= '0;
      gate_q       <= '0;
      rise_q       <= '0;
      gate_ticks_q <= GateReset;
    end else begin
      prev_q       <= prev_d;
      seen_q       <= seen_d;
      period_q     <= period_d;
      high_q       <= high_d;
      gate_q       <= gate_d;
      rise_q       <= rise_d;
      gate_ticks_q <= gate_ticks_d;
    end
  end

endmodule

// File: src/fdm_queue.sv
// ----------------------------------------------------------------------------
// fdm_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module fdm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  fdm_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output fdm_pkg::job_t pop_data_o
);
  import fdm_pkg::*;

  localparam int unsigned PtrWidth = $clog2(QueueDepth);

  job_t                  mem_q [QueueDepth];
  logic [PtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrWidth:0]     count_q, count_d;
  logic                  do_push, do_pop;

  assign push_ready_o = (count_q != (PtrWidth+1)'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + (PtrWidth+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (PtrWidth+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: src/fdm_back.sv
// ----------------------------------------------------------------------------
// fdm_back
// duty computation by bit-serial division and result output register
// ----------------------------------------------------------------------------
module fdm_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pop_valid_i,
  output logic                            pop_ready_o,
  input  fdm_pkg::job_t                   pop_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            kind_o,
  output logic [fdm_pkg::CountWidth-1:0]  edge_count_o,
  output logic [fdm_pkg::CountWidth-1:0]  period_ticks_o,
  output logic [fdm_pkg::CountWidth-1:0]  high_ticks_o,
  output logic [fdm_pkg::DutyWidth-1:0]   duty_percent_o,
  output logic                            last_o
);
  import fdm_pkg::*;

  localparam int unsigned StepWidth = $clog2(QuoWidth);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]            state_q, state_d;
  job_t                  job_q, job_d;
  logic [NumWidth-1:0]   num_q, num_d;
  logic [QuoWidth-1:0]   quo_q, quo_d;
  logic [StepWidth-1:0]  step_q, step_d;
  logic                  gate_pend_q, gate_pend_d;

  logic                  kind_q, kind_d;
  logic [CountWidth-1:0] edges_q, edges_d;
  logic [CountWidth-1:0] period_q, period_d;
  logic [CountWidth-1:0] high_q, high_d;
  logic [DutyWidth-1:0]  duty_q, duty_d;
  logic                  last_q, last_d;

  logic [NumWidth-1:0]   trial;

  assign pop_ready_o    = (state_q == StIdle);
  assign out_valid_o    = (state_q == StOut);
  assign kind_o         = kind_q;
  assign edge_count_o   = edges_q;
  assign period_ticks_o = period_q;
  assign high_ticks_o   = high_q;
  assign duty_percent_o = duty_q;
  assign last_o         = last_q;

  assign trial = NumWidth'(job_q.period) << step_q;

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    num_d       = num_q;
    quo_d       = quo_q;
    step_d      = step_q;
    gate_pend_d = gate_pend_q;
    kind_d      = kind_q;
    edges_d     = edges_q;
    period_d    = period_q;
    high_d      = high_q;
    duty_d      = duty_q;
    last_d      = last_q;

    unique case (state_q)
      StIdle: begin
        if (pop_valid_i) begin
          job_d = pop_data_i;
          if (pop_data_i.has_duty) begin
            state_d = StMul;
          end else begin
            kind_d   = KindGate;
            edges_d  = pop_data_i.edges;
            period_d = '0;
            high_d   = '0;
            duty_d   = '0;
            last_d   = 1'b1;
            state_d  = StOut;
          end
        end
      end
      StMul: begin
        num_d   = NumWidth'(job_q.high) * NumWidth'(100);
        quo_d   = '0;
        step_d  = StepWidth'(QuoWidth - 1);
        state_d = StDiv;
      end
      StDiv: begin
        if (num_q >= trial) begin
          num_d         = num_q - trial;
          quo_d[step_q] = 1'b1;
        end
        if (step_q == '0) begin
          kind_d      = KindDuty;
          edges_d     = '0;
          period_d    = job_q.period;
          high_d      = job_q.high;
          duty_d      = (quo_d > QuoWidth'(DutyPercent)) ? DutyPercent : quo_d[DutyWidth-1:0];
          last_d      = ~job_q.has_gate;
          gate_pend_d = job_q.has_gate;
          state_d     = StOut;
        end else begin
          step_d = step_q - StepWidth'(1);
        end
      end
      StOut: begin
        if (out_ready_i) begin
          if (gate_pend_q) begin
            kind_d      = KindGate;
            edges_d     = job_q.edges;
            period_d    = '0;
            high_d      = '0;
            duty_d      = '0;
            last_d      = 1'b1;
            gate_pend_d = 1'b0;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    num_q    <= num_d;
    quo_q    <= quo_d;
    step_q   <= step_d;
    kind_q   <= kind_d;
    edges_q  <= edges_d;
    period_q <= period_d;
    high_q   <= high_d;
    duty_q   <= duty_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      gate_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gate_pend_q <= gate_pend_d;
    end
  end

endmodule
